[sv/ivps_pkg.sv]
package ivps_pkg;

    // Width of a phase or cycle length in ms (510 min * 60000 ms < 2**25)
    localparam int unsigned CYC_W = 25;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned MS_W = 16;
    localparam int unsigned MIN_W = 8;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [MS_W-1:0] MS_PER_MINUTE = 16'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INSIDE_MIN  = 4'd0,
        REG_OUTSIDE_MIN = 4'd1,
        REG_OVERLAP_MS  = 4'd2,
        REG_PUMP_DELAY  = 4'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_PHASE,
        ST_UPD
    } t_state;

endpackage

[sv/ivps_mod.sv]
// Bit-serial remainder: one dividend bit per cycle, restoring subtract.
module ivps_mod
    import ivps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ELAPSED_W-1:0] i_dividend,
    input  logic [CYC_W-1:0]     i_divisor,
    output logic                 o_done,
    output logic [CYC_W-1:0]     o_rem
);

    localparam int unsigned CNT_W = $clog2(ELAPSED_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [ELAPSED_W-1:0] r_sh;
    logic [CYC_W-1:0]     r_rem;
    logic [CYC_W-1:0]     r_div;
    logic [CYC_W:0]       trial;
    logic [CYC_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_sh[ELAPSED_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = CYC_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[CYC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ELAPSED_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= {r_sh[ELAPSED_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/irrigation_valve_pump_sequencer.sv]
// Channel  Dir  Width  Contents
// s_axis   in   40     tick word: zone requests, schedule flag, elapsed ms
// m_axis   out  8      valve / pump drive levels after the tick
// i_cfg    in   4+16   register write: inside/outside minutes, overlap, pump delay
//
// An accepted tick word passes through a multiply step, an add, the bit-serial
// remainder, phase select and update; the next word is accepted only in idle,
// once the last one has been through update. A new word is taken while the last
// result waits; the update holds off until m_axis drains.
// Synchronous active-low reset restores register defaults.
module irrigation_valve_pump_sequencer
    import ivps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] manual_inside [1] manual_outside [2] remote_inside [3] remote_outside
    // [4] auto_inside [5] auto_outside [6] schedule_active
    // [38:7] schedule_elapsed_ms [39] zero
    input  logic [39:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] pump_on [1] inside_valve_open [2] outside_valve_open
    // [3] tank_valve_open [4] pump_pending [7:5] zero
    output logic [7:0]           m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MS_W-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [MIN_W-1:0] r_cfg_in_min;
    logic [MIN_W-1:0] r_cfg_out_min;
    logic [MS_W-1:0]  r_cfg_overlap;
    logic [MS_W-1:0]  r_cfg_delay;

    // latched word
    logic                 r_req_in_lvl;
    logic                 r_req_out_lvl;
    logic                 r_auto_in;
    logic                 r_auto_out;
    logic                 r_sched;
    logic [ELAPSED_W-1:0] r_elapsed;

    logic [CYC_W-1:0] r_in_ms;
    logic [CYC_W-1:0] r_out_ms;
    logic [CYC_W-1:0] r_cycle;
    logic [CYC_W-1:0] cycle_ms;
    logic             r_inside_ph;
    logic [CYC_W-1:0] r_phase_pos;

    // sequencer state
    logic            r_pump;
    logic            r_wait;
    logic            r_in_vlv;
    logic            r_out_vlv;
    logic            r_tank;
    logic [MS_W-1:0] r_cnt;

    logic            r_m_valid;
    logic [7:0]      r_m_data;

    // fsm controls
    logic in_ready;
    logic div_start;
    logic commit;

    logic             div_done;
    logic [CYC_W-1:0] div_rem;

    logic            req_in, req_out, overlap, fresh;
    logic            n_pump, n_wait, n_in_vlv, n_out_vlv, n_tank;
    logic [MS_W-1:0] n_cnt, cnt_inc;
    logic            out_free;

    assign out_free = !r_m_valid || m_axis_tready;

    // divisor is taken at the same edge that loads r_cycle
    assign cycle_ms = r_in_ms + r_out_ms;

    ivps_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_elapsed),
        .i_divisor  (cycle_ms),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_PHASE;
            ST_PHASE: n_state = ST_UPD;
            ST_UPD:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_SUM:   div_start = 1'b1;
            ST_UPD:   commit = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in_min  <= 8'd10;
            r_cfg_out_min <= 8'd10;
            r_cfg_overlap <= 16'd5000;
            r_cfg_delay   <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INSIDE_MIN:  r_cfg_in_min  <= i_cfg_data[MIN_W-1:0];
                REG_OUTSIDE_MIN: r_cfg_out_min <= i_cfg_data[MIN_W-1:0];
                REG_OVERLAP_MS:  r_cfg_overlap <= i_cfg_data;
                REG_PUMP_DELAY:  r_cfg_delay   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_req_in_lvl  <= s_axis_tdata[0] | s_axis_tdata[2];
            r_req_out_lvl <= s_axis_tdata[1] | s_axis_tdata[3];
            r_auto_in     <= s_axis_tdata[4];
            r_auto_out    <= s_axis_tdata[5];
            r_sched       <= s_axis_tdata[6];
            r_elapsed     <= s_axis_tdata[38:7];
        end
        if (r_state == ST_MUL) begin
            r_in_ms  <= CYC_W'(r_cfg_in_min) * CYC_W'(MS_PER_MINUTE);
            r_out_ms <= CYC_W'(r_cfg_out_min) * CYC_W'(MS_PER_MINUTE);
        end
        if (r_state == ST_SUM) begin
            r_cycle <= cycle_ms;
        end
        if (r_state == ST_PHASE) begin
            r_inside_ph <= div_rem < r_in_ms;
            r_phase_pos <= (div_rem < r_in_ms) ? div_rem : div_rem - r_in_ms;
        end
    end

    always_comb begin
        overlap = r_phase_pos < CYC_W'(r_cfg_overlap);
        if (!r_sched) begin
            req_in  = r_req_in_lvl;
            req_out = r_req_out_lvl;
        end else if (r_cycle == '0) begin
            req_in  = 1'b0;
            req_out = 1'b0;
        end else if (r_inside_ph) begin
            req_in  = r_auto_in;
            req_out = overlap && r_auto_out;
        end else begin
            req_in  = overlap && r_auto_in;
            req_out = r_auto_out;
        end

        cnt_inc = (r_wait && r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
        fresh   = !r_tank || (req_in && !r_in_vlv) || (req_out && !r_out_vlv);

        n_cnt = cnt_inc;
        if (!req_in && !req_out) begin
            n_pump    = 1'b0;
            n_wait    = 1'b0;
            n_in_vlv  = 1'b0;
            n_out_vlv = 1'b0;
            n_tank    = 1'b0;
        end else begin
            n_tank    = 1'b1;
            n_in_vlv  = req_in;
            n_out_vlv = req_out;
            n_pump    = r_pump;
            n_wait    = r_wait;
            if (fresh && !r_pump && !r_wait) begin
                n_wait = 1'b1;
                n_cnt  = '0;
            end
            if (n_wait && n_cnt >= r_cfg_delay) begin
                n_pump = 1'b1;
                n_wait = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump    <= 1'b0;
            r_wait    <= 1'b0;
            r_in_vlv  <= 1'b0;
            r_out_vlv <= 1'b0;
            r_tank    <= 1'b0;
            r_cnt     <= '0;
        end else if (commit) begin
            r_pump    <= n_pump;
            r_wait    <= n_wait;
            r_in_vlv  <= n_in_vlv;
            r_out_vlv <= n_out_vlv;
            r_tank    <= n_tank;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (commit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_m_data <= {3'b000, n_wait, n_tank, n_out_vlv, n_in_vlv, n_pump};
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_pump_not_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pump && r_wait))
        else $error("pump running while still pending");

    a_pump_needs_tank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pump || r_wait || r_in_vlv || r_out_vlv) |-> r_tank)
        else $error("pump or zone valve active with tank valve closed");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_m_valid)
        else $error("update committed without a result word");

    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("remainder finished outside the divide state");

endmodule
